// ----- hw/rtl/ecp_pkg.sv -----
// Shared constants and pipeline flag type for the ellipse radial point clamp.
package ecp_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIUS_X = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIUS_Y = 2'd3;

   typedef struct packed {
      logic valid;
      logic xneg;
      logic yneg;
      logic vert;
      logic vclamp;
      logic interior;
      logic szero;
   } ecp_flags_type;

endpackage

// ----- hw/rtl/ecp_front.sv -----
// Front stages: offsets, squares, cross products, inside test and numerator squares.
module ecp_front #(
   parameter int CB = ecp_pkg::COORD_BITS_DEF,
   localparam int SW = 4 * CB - 1,
   localparam int NW = 6 * CB - 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [CB-1:0]         px_i,
   input  logic [CB-1:0]         py_i,
   input  logic [CB-1:0]         cx,
   input  logic [CB-1:0]         cy,
   input  logic [CB-2:0]         ra,
   input  logic [CB-2:0]         rb,
   output ecp_pkg::ecp_flags_type flags_o,
   output logic [CB-1:0]         px_o,
   output logic [CB-1:0]         py_o,
   output logic [SW-1:0]         s_o,
   output logic [NW-1:0]         nx_o,
   output logic [NW-1:0]         ny_o
);
   import ecp_pkg::*;

   localparam int D2W = 2 * CB;
   localparam int A2W = 2 * (CB - 1);
   localparam int EW  = D2W + A2W;
   localparam int ABW = 2 * A2W;
   localparam int HL  = ABW / 2;
   localparam int HH  = ABW - HL;
   localparam int PPW = HH + D2W;

   ecp_flags_type f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   ecp_flags_type f1_in, f4_in, f5_in;
   logic [CB-1:0]  px1_ff, py1_ff, px2_ff, py2_ff, px3_ff, py3_ff, px4_ff, py4_ff;
   logic [CB-1:0]  px5_ff, py5_ff;
   logic [CB-1:0]  adx1_ff, ady1_ff, adx_in, ady_in;
   logic [D2W-1:0] dx2_ff, dy2_ff, dx23_ff, dy23_ff;
   logic [A2W-1:0] a2_ff, b2_ff;
   logic [EW-1:0]  ex_ff, ey_ff;
   logic [ABW-1:0] ab2_ff;
   logic [SW-1:0]  s4_ff, s5_ff, s_in;
   logic [PPW-1:0] nxl_ff, nxh_ff, nyl_ff, nyh_ff;
   logic [NW-1:0]  nx5_ff, ny5_ff;

   always_comb begin
      f1_in        = '0;
      f1_in.valid  = in_valid;
      f1_in.xneg   = px_i < cx;
      f1_in.yneg   = py_i < cy;
      adx_in       = f1_in.xneg ? cx - px_i : px_i - cx;
      ady_in       = f1_in.yneg ? cy - py_i : py_i - cy;
      f1_in.vert   = adx_in == '0;
      f1_in.vclamp = ady_in >= {1'b0, rb};
   end

   assign s_in = SW'(ex_ff) + SW'(ey_ff);

   always_comb begin
      f4_in          = f3_ff;
      f4_in.interior = s_in < SW'(ab2_ff);
      f5_in          = f4_ff;
      f5_in.szero    = s4_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= '0;
         f2_ff <= '0;
         f3_ff <= '0;
         f4_ff <= '0;
         f5_ff <= '0;
      end else if (adv) begin
         f1_ff <= f1_in;
         f2_ff <= f1_ff;
         f3_ff <= f2_ff;
         f4_ff <= f4_in;
         f5_ff <= f5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff  <= px_i;
         py1_ff  <= py_i;
         adx1_ff <= adx_in;
         ady1_ff <= ady_in;
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         dx2_ff  <= D2W'(adx1_ff) * D2W'(adx1_ff);
         dy2_ff  <= D2W'(ady1_ff) * D2W'(ady1_ff);
         a2_ff   <= A2W'(ra) * A2W'(ra);
         b2_ff   <= A2W'(rb) * A2W'(rb);
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         ex_ff   <= EW'(dx2_ff) * EW'(b2_ff);
         ey_ff   <= EW'(dy2_ff) * EW'(a2_ff);
         ab2_ff  <= ABW'(a2_ff) * ABW'(b2_ff);
         dx23_ff <= dx2_ff;
         dy23_ff <= dy2_ff;
         px4_ff  <= px3_ff;
         py4_ff  <= py3_ff;
         s4_ff   <= s_in;
         nxl_ff  <= PPW'(ab2_ff[HL-1:0]) * PPW'(dx23_ff);
         nxh_ff  <= PPW'(ab2_ff[ABW-1:HL]) * PPW'(dx23_ff);
         nyl_ff  <= PPW'(ab2_ff[HL-1:0]) * PPW'(dy23_ff);
         nyh_ff  <= PPW'(ab2_ff[ABW-1:HL]) * PPW'(dy23_ff);
         px5_ff  <= px4_ff;
         py5_ff  <= py4_ff;
         s5_ff   <= s4_ff;
         nx5_ff  <= (NW'(nxh_ff) << HL) + NW'(nxl_ff);
         ny5_ff  <= (NW'(nyh_ff) << HL) + NW'(nyl_ff);
      end
   end

   assign flags_o = f5_ff;
   assign px_o    = px5_ff;
   assign py_o    = py5_ff;
   assign s_o     = s5_ff;
   assign nx_o    = nx5_ff;
   assign ny_o    = ny5_ff;

endmodule

// ----- hw/rtl/ecp_root_step.sv -----
// One bit of the ray magnitude search for both axes, one register stage.
module ecp_root_step #(
   parameter int CB = ecp_pkg::COORD_BITS_DEF,
   parameter int K = 0,
   localparam int SW = 4 * CB - 1,
   localparam int NW = 6 * CB - 4,
   localparam int QW = 5 * CB - 2,
   localparam int MW = CB - 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  ecp_pkg::ecp_flags_type flags_i,
   input  logic [CB-1:0]          px_i,
   input  logic [CB-1:0]          py_i,
   input  logic [SW-1:0]          s_i,
   input  logic [NW-1:0]          nx_i,
   input  logic [NW-1:0]          ny_i,
   input  logic [NW-1:0]          pxa_i,
   input  logic [NW-1:0]          pya_i,
   input  logic [QW-1:0]          qx_i,
   input  logic [QW-1:0]          qy_i,
   input  logic [MW-1:0]          mx_i,
   input  logic [MW-1:0]          my_i,
   output ecp_pkg::ecp_flags_type flags_o,
   output logic [CB-1:0]          px_o,
   output logic [CB-1:0]          py_o,
   output logic [SW-1:0]          s_o,
   output logic [NW-1:0]          nx_o,
   output logic [NW-1:0]          ny_o,
   output logic [NW-1:0]          pxa_o,
   output logic [NW-1:0]          pya_o,
   output logic [QW-1:0]          qx_o,
   output logic [QW-1:0]          qy_o,
   output logic [MW-1:0]          mx_o,
   output logic [MW-1:0]          my_o
);
   import ecp_pkg::*;

   localparam int PW = 6 * CB;

   ecp_flags_type   flags_ff;
   logic [CB-1:0]   px_ff, py_ff;
   logic [SW-1:0]   s_ff;
   logic [NW-1:0]   nx_ff, ny_ff, pxa_ff, pya_ff;
   logic [QW-1:0]   qx_ff, qy_ff;
   logic [MW-1:0]   mx_ff, my_ff;
   logic [PW-1:0]   candx, candy, sterm;
   logic [QW-1:0]   qstep;
   logic            accx, accy;

   always_comb begin
      sterm = PW'(s_i) << (2 * K);
      qstep = QW'(s_i) << K;
      candx = PW'(pxa_i) + (PW'(qx_i) << (K + 1)) + sterm;
      candy = PW'(pya_i) + (PW'(qy_i) << (K + 1)) + sterm;
      accx  = candx <= PW'(nx_i);
      accy  = candy <= PW'(ny_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (adv) begin
         flags_ff <= flags_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff  <= px_i;
         py_ff  <= py_i;
         s_ff   <= s_i;
         nx_ff  <= nx_i;
         ny_ff  <= ny_i;
         pxa_ff <= accx ? candx[NW-1:0] : pxa_i;
         pya_ff <= accy ? candy[NW-1:0] : pya_i;
         qx_ff  <= accx ? qx_i + qstep : qx_i;
         qy_ff  <= accy ? qy_i + qstep : qy_i;
         mx_ff  <= accx ? (mx_i | (MW'(1) << K)) : mx_i;
         my_ff  <= accy ? (my_i | (MW'(1) << K)) : my_i;
      end
   end

   assign flags_o = flags_ff;
   assign px_o    = px_ff;
   assign py_o    = py_ff;
   assign s_o     = s_ff;
   assign nx_o    = nx_ff;
   assign ny_o    = ny_ff;
   assign pxa_o   = pxa_ff;
   assign pya_o   = pya_ff;
   assign qx_o    = qx_ff;
   assign qy_o    = qy_ff;
   assign mx_o    = mx_ff;
   assign my_o    = my_ff;

endmodule

// ----- hw/rtl/ecp_place.sv -----
// Final stage: choose pass-through, vertical clamp or ray point, add to center, saturate, output register.
module ecp_place #(
   parameter int CB = ecp_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  ecp_pkg::ecp_flags_type flags_i,
   input  logic [CB-1:0]          px_i,
   input  logic [CB-1:0]          py_i,
   input  logic [CB-1:0]          cx,
   input  logic [CB-1:0]          cy,
   input  logic [CB-2:0]          rb,
   input  logic [CB-2:0]          mx_i,
   input  logic [CB-2:0]          my_i,
   output logic                   out_valid,
   output logic [CB-1:0]          tx_o,
   output logic [CB-1:0]          ty_o
);
   import ecp_pkg::*;

   logic          valid_ff;
   logic [CB-1:0] tx_ff, ty_ff, tx_in, ty_in, magx, magy;

   function automatic logic [CB-1:0] place_f(input logic [CB-1:0] c, input logic neg,
                                            input logic [CB-1:0] mag);
      logic signed [CB+1:0] cv;
      logic signed [CB+1:0] mv;
      logic signed [CB+1:0] v;
      logic [CB-1:0]        r;
      cv = signed'({2'b00, c});
      mv = signed'({2'b00, mag});
      v  = neg ? cv - mv : cv + mv;
      if (v < 0) begin
         r = '0;
      end else if (v > signed'({2'b00, {CB{1'b1}}})) begin
         r = '1;
      end else begin
         r = v[CB-1:0];
      end
      return r;
   endfunction

   always_comb begin
      magx = flags_i.szero ? '0 : {1'b0, mx_i};
      magy = flags_i.szero ? '0 : {1'b0, my_i};
      if (flags_i.vert) begin
         tx_in = px_i;
         ty_in = flags_i.vclamp ? place_f(cy, flags_i.yneg, {1'b0, rb}) : py_i;
      end else if (flags_i.interior) begin
         tx_in = px_i;
         ty_in = py_i;
      end else begin
         tx_in = place_f(cx, flags_i.xneg, magx);
         ty_in = place_f(cy, flags_i.yneg, magy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= flags_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
      end
   end

   assign out_valid = valid_ff;
   assign tx_o      = tx_ff;
   assign ty_o      = ty_ff;

endmodule

// ----- hw/rtl/ellipse_radial_point_clamp_core.sv -----
// Top level of the ellipse radial point clamp: config registers and pipeline assembly.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | req_pointer_x, req_pointer_y
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_target_x, rsp_target_y
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One request per cycle while the output is not held; the pipeline has five front stages,
// one search stage per magnitude bit and one output stage.
// The magnitude search steps one bit per stage, so its depth follows COORD_BITS.
// Synchronous reset clears the valid bits and sets the registers to their defaults.
// A stalled result holds the whole pipeline; req_stall rises only then.
module ellipse_radial_point_clamp_core #(
   parameter int COORD_BITS = ecp_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [COORD_BITS-1:0]           req_pointer_x,
   input  logic [COORD_BITS-1:0]           req_pointer_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [COORD_BITS-1:0]           rsp_target_x,
   output logic [COORD_BITS-1:0]           rsp_target_y,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ecp_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]           csr_data
);
   import ecp_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int SW = 4 * CB - 1;
   localparam int NW = 6 * CB - 4;
   localparam int QW = 5 * CB - 2;
   localparam int MW = CB - 1;
   localparam int NST = CB - 1;

   logic [CB-1:0] cx_ff, cy_ff;
   logic [MW-1:0] ra_ff, rb_ff;
   logic          adv;

   ecp_flags_type st_flags [NST+1];
   logic [CB-1:0] st_px    [NST+1];
   logic [CB-1:0] st_py    [NST+1];
   logic [SW-1:0] st_s     [NST+1];
   logic [NW-1:0] st_nx    [NST+1];
   logic [NW-1:0] st_ny    [NST+1];
   logic [NW-1:0] st_pxa   [NST+1];
   logic [NW-1:0] st_pya   [NST+1];
   logic [QW-1:0] st_qx    [NST+1];
   logic [QW-1:0] st_qy    [NST+1];
   logic [MW-1:0] st_mx    [NST+1];
   logic [MW-1:0] st_my    [NST+1];

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         ra_ff <= MW'(1);
         rb_ff <= MW'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTER_X: cx_ff <= csr_data;
            CSR_CENTER_Y: cy_ff <= csr_data;
            CSR_RADIUS_X: ra_ff <= csr_data[MW-1:0];
            CSR_RADIUS_Y: rb_ff <= csr_data[MW-1:0];
            default: ;
         endcase
      end
   end

   ecp_front #(.CB(CB)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .px_i     (req_pointer_x),
      .py_i     (req_pointer_y),
      .cx       (cx_ff),
      .cy       (cy_ff),
      .ra       (ra_ff),
      .rb       (rb_ff),
      .flags_o  (st_flags[0]),
      .px_o     (st_px[0]),
      .py_o     (st_py[0]),
      .s_o      (st_s[0]),
      .nx_o     (st_nx[0]),
      .ny_o     (st_ny[0])
   );

   assign st_pxa[0] = '0;
   assign st_pya[0] = '0;
   assign st_qx[0]  = '0;
   assign st_qy[0]  = '0;
   assign st_mx[0]  = '0;
   assign st_my[0]  = '0;

   for (genvar i = 0; i < NST; i++) begin : g_step
      ecp_root_step #(.CB(CB), .K(NST - 1 - i)) u_step (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .flags_i (st_flags[i]),
         .px_i    (st_px[i]),
         .py_i    (st_py[i]),
         .s_i     (st_s[i]),
         .nx_i    (st_nx[i]),
         .ny_i    (st_ny[i]),
         .pxa_i   (st_pxa[i]),
         .pya_i   (st_pya[i]),
         .qx_i    (st_qx[i]),
         .qy_i    (st_qy[i]),
         .mx_i    (st_mx[i]),
         .my_i    (st_my[i]),
         .flags_o (st_flags[i+1]),
         .px_o    (st_px[i+1]),
         .py_o    (st_py[i+1]),
         .s_o     (st_s[i+1]),
         .nx_o    (st_nx[i+1]),
         .ny_o    (st_ny[i+1]),
         .pxa_o   (st_pxa[i+1]),
         .pya_o   (st_pya[i+1]),
         .qx_o    (st_qx[i+1]),
         .qy_o    (st_qy[i+1]),
         .mx_o    (st_mx[i+1]),
         .my_o    (st_my[i+1])
      );
   end

   ecp_place #(.CB(CB)) u_place (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .flags_i   (st_flags[NST]),
      .px_i      (st_px[NST]),
      .py_i      (st_py[NST]),
      .cx        (cx_ff),
      .cy        (cy_ff),
      .rb        (rb_ff),
      .mx_i      (st_mx[NST]),
      .my_i      (st_my[NST]),
      .out_valid (rsp_valid),
      .tx_o      (rsp_target_x),
      .ty_o      (rsp_target_y)
   );

`ifndef SYNTH
   a_stall_only_on_held_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output hold");

   a_last_stage_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      adv && st_flags[NST].valid |=> rsp_valid)
      else $error("result lost between search and output");

   a_vertical_keeps_x: assert property (@(posedge clock) disable iff (reset)
      adv && st_flags[NST].valid && st_flags[NST].vert |=>
      rsp_target_x == $past(st_px[NST]))
      else $error("vertical ray changed x");
`endif

endmodule
